// File: sv/bgi_pkg.sv
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared types and constants of the bilinear grid interpolator.
// ----------------------------------------------------------------------------
package bgi_pkg;

  // Fixed field widths
  localparam int COORD_W     = 40;  // signed Q24.16 coordinates and origins
  localparam int COORD_FRAC  = 16;
  localparam int RECIP_W     = 32;  // unsigned Q0.32 reciprocal spacing
  localparam int RECIP_FRAC  = 32;
  localparam int SAMPLE_W    = 32;  // signed Q16.16 samples and results
  localparam int FIELD_IDX_W = 6;   // load column and row fields
  localparam int CFG_IDX_W   = 2;

  localparam logic [RECIP_W-1:0] RECIP_RESET = 32'd65536;

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN = 2'd0,
    REG_Y_ORIGIN = 2'd1,
    REG_X_RECIP  = 2'd2,
    REG_Y_RECIP  = 2'd3
  } bgi_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_origin;
    logic signed [COORD_W-1:0] y_origin;
    logic [RECIP_W-1:0]        x_recip;
    logic [RECIP_W-1:0]        y_recip;
  } bgi_cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic                       query;
    logic                       ld_ok;
    logic [FIELD_IDX_W-1:0]     col;
    logic [FIELD_IDX_W-1:0]     row;
    logic signed [SAMPLE_W-1:0] value;
    logic                       x_neg;
    logic [COORD_W-1:0]         dx;
    logic                       y_neg;
    logic [COORD_W-1:0]         dy;
  } bgi_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       oog;
  } bgi_result_t;

endpackage

// File: sv/bgi_fifo.sv
// ----------------------------------------------------------------------------
// bgi_fifo
// Small synchronous queue with registered storage and occupancy count.
// ----------------------------------------------------------------------------
module bgi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

// File: sv/bgi_front.sv
// ----------------------------------------------------------------------------
// bgi_front
// Configuration registers and item classification: checks load addresses
// and takes the grid origin off query coordinates.
// ----------------------------------------------------------------------------
module bgi_front #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bgi_pkg::COORD_W-1:0]           cfg_wdata,
  input  logic                                  func,
  input  logic [bgi_pkg::FIELD_IDX_W-1:0]       load_col,
  input  logic [bgi_pkg::FIELD_IDX_W-1:0]       load_row,
  input  logic signed [bgi_pkg::SAMPLE_W-1:0]   load_value,
  input  logic signed [bgi_pkg::COORD_W-1:0]    point_x,
  input  logic signed [bgi_pkg::COORD_W-1:0]    point_y,
  output bgi_pkg::bgi_cfg_t                     cfg,
  output bgi_pkg::bgi_item_t                    item
);

  import bgi_pkg::*;

  bgi_reg_t                  cfg_reg;
  logic signed [COORD_W:0]   x_diff;
  logic signed [COORD_W:0]   y_diff;

  assign cfg_reg = bgi_reg_t'(cfg_index);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin <= '0;
      cfg.y_origin <= '0;
      cfg.x_recip  <= RECIP_RESET;
      cfg.y_recip  <= RECIP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg)
        REG_X_ORIGIN: cfg.x_origin <= cfg_wdata;
        REG_Y_ORIGIN: cfg.y_origin <= cfg_wdata;
        REG_X_RECIP:  cfg.x_recip  <= cfg_wdata[RECIP_W-1:0];
        REG_Y_RECIP:  cfg.y_recip  <= cfg_wdata[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset from the grid origin, one bit wider so it cannot wrap
  assign x_diff = {point_x[COORD_W-1], point_x} - {cfg.x_origin[COORD_W-1], cfg.x_origin};
  assign y_diff = {point_y[COORD_W-1], point_y} - {cfg.y_origin[COORD_W-1], cfg.y_origin};

  // Classify the item
  always_comb begin
    item.query = (func == FUNC_QUERY);
    item.ld_ok = (int'(load_col) < GRID_COLS) && (int'(load_row) < GRID_ROWS);
    item.col   = load_col;
    item.row   = load_row;
    item.value = load_value;
    item.x_neg = x_diff[COORD_W];
    item.dx    = x_diff[COORD_W-1:0];
    item.y_neg = y_diff[COORD_W];
    item.dy    = y_diff[COORD_W-1:0];
  end

endmodule

// File: sv/bgi_back.sv
// ----------------------------------------------------------------------------
// bgi_back
// Execution pipeline: scale to cell position, clamp, grid store access and
// two-pass bilinear blend. The whole pipeline holds while a result waits.
// ----------------------------------------------------------------------------
module bgi_back #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bgi_pkg::bgi_cfg_t     cfg,
  input  bgi_pkg::bgi_item_t    item,
  input  logic                  item_avail,
  output logic                  item_take,
  output bgi_pkg::bgi_result_t  res,
  output logic                  res_push,
  input  logic                  res_full
);

  import bgi_pkg::*;

  localparam int CW      = $clog2(GRID_COLS);
  localparam int RW      = $clog2(GRID_ROWS);
  localparam int AW      = CW + RW;
  localparam int DEPTH   = 2 ** AW;
  localparam int HALF_W  = COORD_W / 2;
  localparam int PROD_W  = HALF_W + RECIP_W;
  localparam int FULL_W  = COORD_W + RECIP_W;
  localparam int POS_LSB = COORD_FRAC + RECIP_FRAC - FRAC_BITS;
  localparam int POS_W   = FULL_W - POS_LSB;
  localparam int WGT_W   = FRAC_BITS + 2;
  localparam int ACC_W   = SAMPLE_W + WGT_W + 1;

  localparam logic [CW-1:0]    X_LAST = CW'(GRID_COLS - 1);
  localparam logic [RW-1:0]    Y_LAST = RW'(GRID_ROWS - 1);
  localparam logic [POS_W-1:0] X_LIM  = POS_W'(GRID_COLS - 1) << FRAC_BITS;
  localparam logic [POS_W-1:0] Y_LIM  = POS_W'(GRID_ROWS - 1) << FRAC_BITS;
  localparam logic [WGT_W-1:0] W_ONE  = WGT_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  // a*(1-w) + b*w, rounded to nearest by floor after adding a half
  function automatic logic signed [SAMPLE_W-1:0] blend(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [FRAC_BITS-1:0]       w
  );
    logic signed [WGT_W-1:0] wa;
    logic signed [WGT_W-1:0] wb;
    logic signed [ACC_W-1:0] acc;
    wb  = $signed(WGT_W'(w));
    wa  = $signed(W_ONE - WGT_W'(w));
    acc = a * wa + b * wb + HALF;
    return acc[FRAC_BITS +: SAMPLE_W];
  endfunction

  logic adv;

  // Stage 1: partial products
  logic                       p1_valid, p1_query, p1_ld_ok, p1_x_neg, p1_y_neg;
  logic [FIELD_IDX_W-1:0]     p1_col, p1_row;
  logic signed [SAMPLE_W-1:0] p1_value;
  logic [PROD_W-1:0]          p1_xh, p1_xl, p1_yh, p1_yl;

  // Stage 2: located cell
  logic                       p2_valid, p2_query, p2_ld_ok, p2_oog;
  logic [FIELD_IDX_W-1:0]     p2_col, p2_row;
  logic signed [SAMPLE_W-1:0] p2_value;
  logic [CW-1:0]              p2_x0, p2_x1;
  logic [RW-1:0]              p2_y0, p2_y1;
  logic [FRAC_BITS-1:0]       p2_fx, p2_fy;

  // Stage 3: samples
  logic                       p3_valid, p3_oog;
  logic [FRAC_BITS-1:0]       p3_fx, p3_fy;
  logic signed [SAMPLE_W-1:0] s00, s01, s10, s11;

  // Stage 4: row blends
  logic                       p4_valid, p4_oog;
  logic [FRAC_BITS-1:0]       p4_fy;
  logic signed [SAMPLE_W-1:0] p4_r0, p4_r1;

  // Locate combinational signals
  logic [FULL_W-1:0]    x_full, y_full;
  logic [POS_W-1:0]     x_pos, y_pos;
  logic [CW-1:0]        x0, x1;
  logic [RW-1:0]        y0, y1;
  logic [FRAC_BITS-1:0] fx, fy;
  logic                 x_oog, y_oog;

  // Grid store, two copies so that four samples are read each cycle
  logic [SAMPLE_W-1:0] mem_a [DEPTH];
  logic [SAMPLE_W-1:0] mem_b [DEPTH];
  logic [AW-1:0]       wr_addr;
  logic                mem_we;

  // Pipeline advances unless a finished result cannot be queued
  assign adv       = !(p4_valid && res_full);
  assign item_take = adv && item_avail;

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= item_avail;
    end
  end

  // Stage 1 payload: split the 40-bit offset into two 20-bit halves
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_query <= item.query;
      p1_ld_ok <= item.ld_ok;
      p1_col   <= item.col;
      p1_row   <= item.row;
      p1_value <= item.value;
      p1_x_neg <= item.x_neg;
      p1_y_neg <= item.y_neg;
      p1_xh    <= item.dx[COORD_W-1:HALF_W] * cfg.x_recip;
      p1_xl    <= item.dx[HALF_W-1:0] * cfg.x_recip;
      p1_yh    <= item.dy[COORD_W-1:HALF_W] * cfg.y_recip;
      p1_yl    <= item.dy[HALF_W-1:0] * cfg.y_recip;
    end
  end

  // Cell position, clamp to the grid edge
  always_comb begin
    x_full = {p1_xh, HALF_W'(0)} + FULL_W'(p1_xl);
    y_full = {p1_yh, HALF_W'(0)} + FULL_W'(p1_yl);
    x_pos  = x_full[FULL_W-1:POS_LSB];
    y_pos  = y_full[FULL_W-1:POS_LSB];

    if (p1_x_neg) begin
      x0    = '0;
      fx    = '0;
      x_oog = 1'b1;
    end else if (x_pos > X_LIM) begin
      x0    = X_LAST;
      fx    = '0;
      x_oog = 1'b1;
    end else begin
      x0    = x_pos[FRAC_BITS +: CW];
      fx    = x_pos[FRAC_BITS-1:0];
      x_oog = 1'b0;
    end
    // Below the grid both neighbours sit on the first line
    x1 = (x0 == X_LAST || p1_x_neg) ? x0 : x0 + 1'b1;

    if (p1_y_neg) begin
      y0    = '0;
      fy    = '0;
      y_oog = 1'b1;
    end else if (y_pos > Y_LIM) begin
      y0    = Y_LAST;
      fy    = '0;
      y_oog = 1'b1;
    end else begin
      y0    = y_pos[FRAC_BITS +: RW];
      fy    = y_pos[FRAC_BITS-1:0];
      y_oog = 1'b0;
    end
    y1 = (y0 == Y_LAST || p1_y_neg) ? y0 : y0 + 1'b1;
  end

  // Stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid;
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_query <= p1_query;
      p2_ld_ok <= p1_ld_ok;
      p2_col   <= p1_col;
      p2_row   <= p1_row;
      p2_value <= p1_value;
      p2_x0    <= x0;
      p2_x1    <= x1;
      p2_y0    <= y0;
      p2_y1    <= y1;
      p2_fx    <= fx;
      p2_fy    <= fy;
      p2_oog   <= x_oog || y_oog;
    end
  end

  // Loads write here and retire; queries read their four samples
  assign mem_we  = adv && p2_valid && !p2_query && p2_ld_ok;
  assign wr_addr = {RW'(p2_row), CW'(p2_col)};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (mem_we) begin
        mem_a[wr_addr] <= p2_value;
      end
      s00 <= mem_a[{p2_y0, p2_x0}];
      s01 <= mem_a[{p2_y0, p2_x1}];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (mem_we) begin
        mem_b[wr_addr] <= p2_value;
      end
      s10 <= mem_b[{p2_y1, p2_x0}];
      s11 <= mem_b[{p2_y1, p2_x1}];
    end
  end

  // Stage 3 control
  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (adv) begin
      p3_valid <= p2_valid && p2_query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_fx  <= p2_fx;
      p3_fy  <= p2_fy;
      p3_oog <= p2_oog;
    end
  end

  // Stage 4: blend along x for both rows
  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (adv) begin
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r0  <= blend(s00, s01, p3_fx);
      p4_r1  <= blend(s10, s11, p3_fx);
      p4_fy  <= p3_fy;
      p4_oog <= p3_oog;
    end
  end

  // Blend along y into the result queue
  assign res.value = blend(p4_r0, p4_r1, p4_fy);
  assign res.oog   = p4_oog;
  assign res_push  = p4_valid && adv;

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (p2_valid && p2_query) |-> ((p2_x0 <= X_LAST) && (p2_y0 <= Y_LAST)))
    else $error("cell index beyond grid");

  a_neighbour: assert property (@(posedge clk) disable iff (rst)
    (p2_valid && p2_query && (p2_fx != '0)) |-> (p2_x1 == p2_x0 + 1'b1))
    else $error("x neighbour not adjacent under nonzero weight");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!adv && p4_valid) |=> (p4_valid && $stable(p4_r0) && $stable(p4_r1)))
    else $error("stalled result changed");

endmodule

// File: sv/bilinear_grid_interpolator.sv
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator
// Bilinear lookup into a regular 2-D grid of Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on a queue-style port: an item is taken when push is high
//   and full is low. func 0 loads one sample into the grid store (no
//   result); func 1 queries the point (point_x, point_y) and gives one
//   result. Results leave on a queue-style port: the oldest result is shown
//   while empty is low and is taken when pop is high.
//   Registers (origins, reciprocal spacings) are written through cfg_we,
//   cfg_index and cfg_wdata while no item is in flight.
//   Throughput is one item per cycle while a full result queue does not hold
//   the pipeline; the store is held twice so the four corner samples of a query
//   are read together. A query's result passes through the input queue, scaling
//   multiply, locate and clamp, store read, x blend, then the result queue.
//   Points outside the grid are clamped to the edge and flagged.
//   Reset empties both queues and the pipeline and restores the register
//   defaults; the grid store is not cleared and must be loaded before use.
//   While pop stays low the pipeline holds once the result queue fills and
//   the input queue then fills in turn; no item or result is dropped.
// ----------------------------------------------------------------------------
module bilinear_grid_interpolator #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bgi_pkg::COORD_W-1:0]          cfg_wdata,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 func,
  input  logic [bgi_pkg::FIELD_IDX_W-1:0]      load_col,
  input  logic [bgi_pkg::FIELD_IDX_W-1:0]      load_row,
  input  logic signed [bgi_pkg::SAMPLE_W-1:0]  load_value,
  input  logic signed [bgi_pkg::COORD_W-1:0]   point_x,
  input  logic signed [bgi_pkg::COORD_W-1:0]   point_y,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [bgi_pkg::SAMPLE_W-1:0]  interp_value,
  output logic                                 out_of_grid
);

  import bgi_pkg::*;

  localparam int ITEM_W  = $bits(bgi_item_t);
  localparam int RES_W   = $bits(bgi_result_t);
  localparam int Q_DEPTH = 4;

  bgi_cfg_t    cfg;
  bgi_item_t   front_item;
  bgi_item_t   back_item;
  bgi_result_t back_res;
  bgi_result_t out_res;
  logic        mid_empty;
  logic        mid_pop;
  logic        res_push;
  logic        res_full;

  // Front: registers and classification
  bgi_front #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .func       (func),
    .load_col   (load_col),
    .load_row   (load_row),
    .load_value (load_value),
    .point_x    (point_x),
    .point_y    (point_y),
    .cfg        (cfg),
    .item       (front_item)
  );

  // Queue between front and back
  bgi_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (Q_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (mid_pop),
    .rdata (back_item),
    .empty (mid_empty)
  );

  // Back: execution pipeline and grid store
  bgi_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (back_item),
    .item_avail (!mid_empty),
    .item_take  (mid_pop),
    .res        (back_res),
    .res_push   (res_push),
    .res_full   (res_full)
  );

  // Result queue
  bgi_fifo #(
    .WIDTH (RES_W),
    .DEPTH (Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign interp_value = out_res.value;
  assign out_of_grid  = out_res.oog;

endmodule

// File: tb/tb_bilinear_grid_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_grid_interpolator
// Self-checking bench for the bilinear grid interpolator. Loads and queries
// are queued by the stimulus process and handed to a clocked driver. Each
// accepted item runs through a fixed-point model of the grid and its blend.
// A clocked monitor compares every popped result with the oldest predicted
// one. The run steps through several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_bilinear_grid_interpolator;
  import bgi_pkg::*;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int FRAC      = 16;
  localparam int WDOG_LIMIT = 3000;
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                       func;
    logic [FIELD_IDX_W-1:0]     col;
    logic [FIELD_IDX_W-1:0]     row;
    logic signed [SAMPLE_W-1:0] val;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
  } grid_item_t;

  // DUT ports; the inputs are all known from time zero
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [COORD_W-1:0]         cfg_wdata = '0;
  logic                       push = 1'b0;
  logic                       full;
  logic                       func = 1'b0;
  logic [FIELD_IDX_W-1:0]     load_col = '0;
  logic [FIELD_IDX_W-1:0]     load_row = '0;
  logic signed [SAMPLE_W-1:0] load_value = '0;
  logic signed [COORD_W-1:0]  point_x = '0;
  logic signed [COORD_W-1:0]  point_y = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [SAMPLE_W-1:0] interp_value;
  logic                       out_of_grid;

  // Bench state
  grid_item_t  item_q[$];
  bgi_result_t interp_due_q[$];
  grid_item_t  drive_item;
  bgi_result_t due;
  bgi_cfg_t    cfg_now;
  logic signed [SAMPLE_W-1:0] grid_mem [GRID_COLS*GRID_ROWS];
  bit          loaded_map [GRID_COLS*GRID_ROWS];
  idle_mode_t  idle_mode = IDLE_NONE;
  int          fails = 0;
  int          quiet_cycles = 0;
  int          n_items = 0;

  bilinear_grid_interpolator u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .func         (func),
    .load_col     (load_col),
    .load_row     (load_row),
    .load_value   (load_value),
    .point_x      (point_x),
    .point_y      (point_y),
    .empty        (empty),
    .pop          (pop),
    .interp_value (interp_value),
    .out_of_grid  (out_of_grid)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Fixed-point model
  // --------------------------------------------------------------------------

  // Coordinate to lower/upper cell index and weight; returns the clamp flag
  function automatic bit cell_locate(input logic signed [COORD_W-1:0] pt,
                                     input logic signed [COORD_W-1:0] org,
                                     input logic [RECIP_W-1:0] recip,
                                     input int cells, output int lo,
                                     output int hi, output longint wt);
    longint      d;
    logic [79:0] prod;
    logic [63:0] pos;
    longint      idx;
    longint      frac;
    bit          clamped;
    d = longint'(pt) - longint'(org);
    if (d < 0) begin
      lo = 0;
      hi = 0;
      wt = 0;
      return 1'b1;
    end
    prod = {16'b0, 64'(d)} * {48'b0, recip};
    pos  = 64'(prod >> (48 - FRAC));
    idx  = longint'(pos >> FRAC);
    frac = longint'(pos & ((64'd1 << FRAC) - 1));
    clamped = 1'b0;
    if (idx > cells - 1 || (idx == cells - 1 && frac != 0)) begin
      idx = cells - 1;
      frac = 0;
      clamped = 1'b1;
    end
    lo = int'(idx);
    hi = (idx + 1 < cells) ? int'(idx) + 1 : int'(idx);
    wt = frac;
    return clamped;
  endfunction

  // One linear blend step, rounded half up to Q16.16
  function automatic longint mix(input longint a, input longint b, input longint w);
    longint acc;
    acc = a * ((longint'(1) << FRAC) - w) + b * w + (longint'(1) << (FRAC - 1));
    return acc >>> FRAC;
  endfunction

  function automatic longint sample_at(input int col, input int row);
    return longint'(grid_mem[row*GRID_COLS + col]);
  endfunction

  function automatic bgi_result_t interp_at(input grid_item_t it);
    int          x0, x1, y0, y1;
    longint      fx, fy, r0, r1, v;
    bit          ox, oy;
    bgi_result_t res;
    ox = cell_locate(it.px, cfg_now.x_origin, cfg_now.x_recip, GRID_COLS, x0, x1, fx);
    oy = cell_locate(it.py, cfg_now.y_origin, cfg_now.y_recip, GRID_ROWS, y0, y1, fy);
    r0 = mix(sample_at(x0, y0), sample_at(x1, y0), fx);
    r1 = mix(sample_at(x0, y1), sample_at(x1, y1), fx);
    v  = mix(r0, r1, fy);
    res.value = v[SAMPLE_W-1:0];
    res.oog   = ox | oy;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Idling
  // --------------------------------------------------------------------------

  function automatic bit sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    return (idle_mode == IDLE_SEND && r < 65) || (idle_mode == IDLE_BOTH && r < 23);
  endfunction

  function automatic bit receiver_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    return (idle_mode == IDLE_RECV && r < 65) || (idle_mode == IDLE_BOTH && r < 23);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued items, predict on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (drive_item.func == FUNC_LOAD)
          grid_mem[drive_item.row*GRID_COLS + drive_item.col] = drive_item.val;
        else
          interp_due_q = {interp_due_q, interp_at(drive_item)};
      end
      if (!push || !full) begin
        if (item_q.size() != 0 && !sender_gap()) begin
          drive_item = item_q.pop_front();
          push       <= 1'b1;
          func       <= drive_item.func;
          load_col   <= drive_item.col;
          load_row   <= drive_item.row;
          load_value <= drive_item.val;
          point_x    <= drive_item.px;
          point_y    <= drive_item.py;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: pop results and compare with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (interp_due_q.size() == 0) begin
          $display("%0t: result with none expected: value %h flag %b",
                   $time, interp_value, out_of_grid);
          fails++;
        end else begin
          due = interp_due_q.pop_front();
          if (interp_value !== due.value) begin
            $display("%0t: interp_value mismatch: expected %h actual %h",
                     $time, due.value, interp_value);
            fails++;
          end
          if (out_of_grid !== due.oog) begin
            $display("%0t: out_of_grid mismatch: expected %b actual %b",
                     $time, due.oog, out_of_grid);
            fails++;
          end
        end
      end
      pop <= !receiver_stall();
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no item or result accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic reg_write(input bgi_reg_t idx, input logic [COORD_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_X_ORIGIN: cfg_now.x_origin = data;
      REG_Y_ORIGIN: cfg_now.y_origin = data;
      REG_X_RECIP:  cfg_now.x_recip  = data[RECIP_W-1:0];
      REG_Y_RECIP:  cfg_now.y_recip  = data[RECIP_W-1:0];
      default: ;
    endcase
  endtask

  // Write all four registers; noise above the reciprocal width must be ignored
  task automatic set_config(input logic signed [COORD_W-1:0] xo,
                            input logic signed [COORD_W-1:0] yo,
                            input logic [RECIP_W-1:0] xr, input logic [RECIP_W-1:0] yr);
    reg_write(REG_X_ORIGIN, xo);
    reg_write(REG_Y_ORIGIN, yo);
    reg_write(REG_X_RECIP, {8'($urandom), xr});
    reg_write(REG_Y_RECIP, {8'($urandom), yr});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Block idle: nothing queued, nothing presented, no result outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (item_q.size() != 0 || push || interp_due_q.size() != 0);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand40();
    return COORD_W'({$urandom, $urandom});
  endfunction

  task automatic add_load(input int col, input int row, input logic [SAMPLE_W-1:0] val);
    grid_item_t it;
    it.func = FUNC_LOAD;
    it.col  = col[FIELD_IDX_W-1:0];
    it.row  = row[FIELD_IDX_W-1:0];
    it.val  = val;
    it.px   = rand40();
    it.py   = rand40();
    loaded_map[row*GRID_COLS + col] = 1'b1;
    item_q = {item_q, it};
    n_items++;
  endtask

  // Queue a query, first loading any corner it reads that was never written
  task automatic add_query(input logic signed [COORD_W-1:0] px,
                           input logic signed [COORD_W-1:0] py);
    grid_item_t it;
    int         x0, x1, y0, y1;
    longint     fx, fy;
    bit         ox, oy;
    int         cx [4];
    int         cy [4];
    ox = cell_locate(px, cfg_now.x_origin, cfg_now.x_recip, GRID_COLS, x0, x1, fx);
    oy = cell_locate(py, cfg_now.y_origin, cfg_now.y_recip, GRID_ROWS, y0, y1, fy);
    cx = '{x0, x1, x0, x1};
    cy = '{y0, y0, y1, y1};
    for (int i = 0; i < 4; i++)
      if (!loaded_map[cy[i]*GRID_COLS + cx[i]])
        add_load(cx[i], cy[i], $urandom);
    it.func = FUNC_QUERY;
    it.col  = FIELD_IDX_W'($urandom);
    it.row  = FIELD_IDX_W'($urandom);
    it.val  = $urandom;
    it.px   = px;
    it.py   = py;
    item_q = {item_q, it};
    n_items++;
  endtask

  // Coordinate mostly inside the grid, with some on grid lines, below and random
  function automatic logic signed [COORD_W-1:0] pick_coord(
      input logic signed [COORD_W-1:0] org, input logic [RECIP_W-1:0] recip);
    longint      d, lim, pt;
    int unsigned sel, k;
    sel = $urandom_range(0, 99);
    if (sel < 20) return rand40();
    if (sel < 30) begin
      d = -longint'($urandom_range(1, 1 << 20));
    end else if (sel < 42 && recip != 0) begin
      k = $urandom_range(0, 63);
      d = ((longint'(k) << 48) + longint'(recip) - 1) / longint'(recip);
    end else begin
      lim = (recip == 0) ? (longint'(1) << 39) : (longint'(1) << 54) / longint'(recip);
      lim = lim + lim / 16 + 1;
      if (lim > (longint'(1) << 39)) lim = longint'(1) << 39;
      d = longint'({$urandom, $urandom} >> 1) % lim;
    end
    pt = longint'(org) + d;
    if (pt > COORD_MAX || pt < COORD_MIN) return rand40();
    return pt[COORD_W-1:0];
  endfunction

  // About n items per phase, corner loads included
  task automatic random_phase(input idle_mode_t mode,
                              input logic signed [COORD_W-1:0] xo,
                              input logic signed [COORD_W-1:0] yo,
                              input logic [RECIP_W-1:0] xr, input logic [RECIP_W-1:0] yr,
                              input int n);
    int stop;
    wait_drained();
    set_config(xo, yo, xr, yr);
    idle_mode = mode;
    stop = n_items + n;
    while (n_items < stop) begin
      if ($urandom_range(0, 99) < 30)
        add_load($urandom_range(0, GRID_COLS - 1), $urandom_range(0, GRID_ROWS - 1),
                 $urandom);
      else
        add_query(pick_coord(cfg_now.x_origin, cfg_now.x_recip),
                  pick_coord(cfg_now.y_origin, cfg_now.y_recip));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_now.x_origin = '0;
    cfg_now.y_origin = '0;
    cfg_now.x_recip  = RECIP_RESET;
    cfg_now.y_recip  = RECIP_RESET;
    for (int i = 0; i < GRID_COLS*GRID_ROWS; i++) begin
      grid_mem[i]   = '0;
      loaded_map[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: one cell spans 2^32 raw units with the default spacing
    set_config('0, '0, RECIP_RESET, RECIP_RESET);
    idle_mode = IDLE_NONE;
    add_load(0, 0, 32'h7FFF_FFFF);
    add_load(1, 0, 32'h8000_0000);
    add_load(0, 1, 32'h8000_0000);
    add_load(1, 1, 32'h7FFF_FFFF);
    add_query(40'sd0, 40'sd0);                            // on a node
    add_query(40'sh00_8000_0000, 40'sh00_8000_0000);      // cell centre
    add_query(40'sh00_FFFF_FFFF, 40'sh00_FFFF_FFFF);      // largest weight
    add_query(40'sh00_FFFF_FFFF, 40'sd0);
    add_load(63, 63, 32'h8000_0000);
    add_load(62, 63, 32'h7FFF_FFFF);
    add_query(40'sh3F_0000_0000, 40'sh3F_0000_0000);      // exactly on last lines
    add_query(40'sh3F_0000_0001, 40'sh3E_8000_0000);      // last line, weight still zero
    add_query(40'sh3F_0001_0000, 40'sh3F_0000_0000);      // just beyond in x
    add_query(40'sh3E_8000_0000, 40'sh3F_0001_0000);      // just beyond in y
    add_query(-40'sd1, 40'sh01_8000_0000);                // just below in x
    add_query(40'sh01_8000_0000, -40'sd1);                // just below in y
    add_query(40'sh7F_FFFF_FFFF, 40'sh80_0000_0000);      // coordinate extremes
    add_query(40'sh80_0000_0000, 40'sh7F_FFFF_FFFF);
    add_query(40'sh7F_FFFF_FFFF, 40'sh7F_FFFF_FFFF);

    // Random phases across register extremes and idling patterns
    random_phase(IDLE_SEND, -40'sd229376, 40'sd98304, 32'd65536 * 3, 32'd400000, 160);
    random_phase(IDLE_RECV, 40'sh7F_FFFF_FFFF, 40'sh80_0000_0000,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 160);
    random_phase(IDLE_BOTH, rand40() >>> 8, rand40() >>> 8, 32'd0, $urandom, 160);
    random_phase(IDLE_NONE, rand40(), rand40(), $urandom, $urandom, 160);
    random_phase(IDLE_SEND, 40'sh80_0000_0000, 40'sh7F_FFFF_FFFF, 32'd1, 32'd0, 160);
    random_phase(IDLE_RECV, rand40() >>> 4, rand40() >>> 4,
                 $urandom_range(32'd65536, 32'h00FF_FFFF),
                 $urandom_range(32'd65536, 32'h0FFF_FFFF), 160);
    random_phase(IDLE_BOTH, -40'sd65536, -40'sd65536, 32'hFFFF_FFFF,
                 $urandom_range(32'h0100_0000, 32'hFFFF_FFFF), 160);

    // Drain, then allow time for anything stray to appear
    do @(negedge clk);
    while (item_q.size() != 0 || push || interp_due_q.size() != 0);
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
